// ===== hw/rtl/minimum_spanning_tree_engine_assert.svh =====
// Assertion macros for the minimum spanning tree engine checker.
// Depends on nothing; included by the checker file.
`ifndef MINIMUM_SPANNING_TREE_ENGINE_ASSERT_SVH
`define MINIMUM_SPANNING_TREE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define MSTE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset
`define MSTE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mste_pkg.sv =====
// Shared constants, types and state codes of the minimum spanning tree engine.
// Depends on nothing; used by the interfaces, the top level and the checker.
package mste_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VTX_BITS     = $clog2(MAX_VERTICES);
   localparam int VCNT_BITS    = 7;
   localparam int MAX_EDGES    = 256;
   localparam int EIDX_BITS    = $clog2(MAX_EDGES);
   localparam int ECNT_BITS    = EIDX_BITS + 1;
   localparam int WEIGHT_BITS  = 16;
   localparam int SUM_BITS     = 22;
   localparam int RANK_BITS    = 3;

   localparam logic signed [SUM_BITS:0] SUM_MAX = 23'sd2097151;
   localparam logic signed [SUM_BITS:0] SUM_MIN = -23'sd2097152;

   typedef struct packed {
      logic [VTX_BITS-1:0]           a;
      logic [VTX_BITS-1:0]           b;
      logic signed [WEIGHT_BITS-1:0] w;
   } edge_type;

   typedef struct packed {
      logic [RANK_BITS-1:0] rank;
      logic [VTX_BITS-1:0]  parent;
   } node_type;

   // Controller state codes
   localparam logic [3:0] ST_LOAD     = 4'd0;
   localparam logic [3:0] ST_CLEAR    = 4'd1;
   localparam logic [3:0] ST_SCAN     = 4'd2;
   localparam logic [3:0] ST_FIND_RD  = 4'd3;
   localparam logic [3:0] ST_FIND_CHK = 4'd4;
   localparam logic [3:0] ST_JOIN     = 4'd5;
   localparam logic [3:0] ST_JOIN2    = 4'd6;
   localparam logic [3:0] ST_EMIT     = 4'd7;
   localparam logic [3:0] ST_FINISH   = 4'd8;

endpackage

// ===== hw/rtl/mste_if.sv =====
// Channel interfaces of the minimum spanning tree engine: edge requests,
// tree results and the vertex count register write. Depends on mste_pkg.
interface mste_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [mste_pkg::VTX_BITS-1:0]           edge_from;
   logic [mste_pkg::VTX_BITS-1:0]           edge_to;
   logic signed [mste_pkg::WEIGHT_BITS-1:0] edge_weight;
   logic                                    edge_last;
   modport source (output valid, edge_from, edge_to, edge_weight, edge_last, input ready);
   modport sink (input valid, edge_from, edge_to, edge_weight, edge_last, output ready);
endinterface

interface mste_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic [mste_pkg::VTX_BITS-1:0]           tree_from;
   logic [mste_pkg::VTX_BITS-1:0]           tree_to;
   logic signed [mste_pkg::WEIGHT_BITS-1:0] tree_weight;
   logic                                    edge_taken;
   logic signed [mste_pkg::SUM_BITS-1:0]    total_weight;
   logic                                    dropped_edges;
   logic                                    result_last;
   modport source (output valid, tree_from, tree_to, tree_weight, edge_taken, total_weight,
                   dropped_edges, result_last, input ready);
   modport sink (input valid, tree_from, tree_to, tree_weight, edge_taken, total_weight,
                 dropped_edges, result_last, output ready);
endinterface

interface mste_csr_if;
   logic                               valid;
   logic                               ready;
   logic [mste_pkg::VCNT_BITS-1:0]     vertex_count;
   modport source (output valid, vertex_count, input ready);
   modport sink (input valid, vertex_count, output ready);
endinterface

// ===== hw/rtl/minimum_spanning_tree_engine.sv =====
// Minimum spanning tree engine top level: edge store, union-find memory and
// run controller. Depends on mste_pkg and the channel interfaces in mste_if.
//
// Edges load one per cycle into a 256-entry edge store while the engine is
// idle. The request carrying edge_last starts a run and no request is taken
// until the run ends. A run clears the 64-entry union-find memory, then
// repeats a scan of the edge store for the next edge in (weight, arrival)
// order. Each selected edge then walks the parent chain of both endpoints,
// with a read state and a check state per memory step, and a union takes
// one or two writes. Results leave through an output register; each result
// is held back until the next one is known so that the final one can carry
// result_last.
module minimum_spanning_tree_engine (
   input  logic       clock,
   input  logic       reset,
   mste_req_if.sink   req_if,
   mste_rsp_if.source rsp_if,
   mste_csr_if.sink   csr_if
);

   localparam int VB = mste_pkg::VTX_BITS;
   localparam int WB = mste_pkg::WEIGHT_BITS;
   localparam int SB = mste_pkg::SUM_BITS;

   // Memories
   mste_pkg::edge_type edge_mem [mste_pkg::MAX_EDGES];
   mste_pkg::node_type node_mem [mste_pkg::MAX_VERTICES];

   mste_pkg::edge_type edge_rd_ff;
   mste_pkg::node_type node_rd_ff;

   logic                              ew_en;
   logic [mste_pkg::EIDX_BITS-1:0]    ew_addr;
   mste_pkg::edge_type                ew_data;
   logic [mste_pkg::EIDX_BITS-1:0]    er_addr;
   logic                              nw_en;
   logic [VB-1:0]                     nw_addr;
   mste_pkg::node_type                nw_data;
   logic [VB-1:0]                     nr_addr;

   // Control and datapath registers
   logic [3:0]                     state_ff, state_in;
   logic [mste_pkg::VCNT_BITS-1:0] vcount_ff, vcount_in;
   logic [mste_pkg::ECNT_BITS-1:0] count_ff, count_in;
   logic                           drop_ff, drop_in;
   logic signed [SB-1:0]           sum_ff, sum_in;
   logic [VB-1:0]                  clr_ff, clr_in;
   logic [mste_pkg::ECNT_BITS-1:0] iss_ff, iss_in;
   logic                           chk_v_ff, chk_v_in;
   logic [mste_pkg::EIDX_BITS-1:0] chk_i_ff, chk_i_in;
   logic                           first_ff, first_in;
   logic signed [WB-1:0]           prev_w_ff, prev_w_in;
   logic [mste_pkg::EIDX_BITS-1:0] prev_i_ff, prev_i_in;
   logic                           best_v_ff, best_v_in;
   mste_pkg::edge_type             best_ff, best_in;
   logic [mste_pkg::EIDX_BITS-1:0] best_i_ff, best_i_in;
   mste_pkg::edge_type             cur_ff, cur_in;
   logic [VB-1:0]                  x_ff, x_in;
   logic                           side_ff, side_in;
   logic [VB-1:0]                  ra_ff, ra_in, rb_ff, rb_in;
   logic [mste_pkg::RANK_BITS-1:0] rka_ff, rka_in, rkb_ff, rkb_in;
   logic                           pend_v_ff, pend_v_in;
   mste_pkg::edge_type             pend_ff, pend_in;
   logic signed [SB-1:0]           pend_sum_ff, pend_sum_in;
   logic                           out_v_ff, out_v_in;
   mste_pkg::edge_type             out_ff, out_in;
   logic                           out_tk_ff, out_tk_in;
   logic signed [SB-1:0]           out_sum_ff, out_sum_in;
   logic                           out_drop_ff, out_drop_in;
   logic                           out_last_ff, out_last_in;

   logic [mste_pkg::VCNT_BITS-1:0] nv;
   logic                           req_fire;
   logic                           req_ok;
   logic                           out_free;
   logic                           e_good;
   logic                           e_after;
   logic                           e_before;
   logic signed [SB:0]             sum_wide;

   // Clamp the vertex count to its usable range
   always_comb begin
      if (vcount_ff == '0) begin
         nv = mste_pkg::VCNT_BITS'(1);
      end else if (vcount_ff > mste_pkg::VCNT_BITS'(mste_pkg::MAX_VERTICES)) begin
         nv = mste_pkg::VCNT_BITS'(mste_pkg::MAX_VERTICES);
      end else begin
         nv = vcount_ff;
      end
   end

   assign req_if.ready = (state_ff == mste_pkg::ST_LOAD);
   assign csr_if.ready = 1'b1;
   assign req_fire     = req_if.valid && req_if.ready;
   assign req_ok       = ({1'b0, req_if.edge_from} < nv) && ({1'b0, req_if.edge_to} < nv)
                         && !count_ff[mste_pkg::ECNT_BITS-1];
   assign out_free     = !out_v_ff || rsp_if.ready;

   // Scan compare: vertex check, strictly after the previous pick, before the best so far
   assign e_good   = ({1'b0, edge_rd_ff.a} < nv) && ({1'b0, edge_rd_ff.b} < nv);
   assign e_after  = first_ff || (edge_rd_ff.w > prev_w_ff)
                     || ((edge_rd_ff.w == prev_w_ff) && (chk_i_ff > prev_i_ff));
   assign e_before = !best_v_ff || (edge_rd_ff.w < best_ff.w);

   // Saturating running sum
   assign sum_wide = (SB+1)'(sum_ff) + (SB+1)'(cur_ff.w);

   always_comb begin
      state_in    = state_ff;
      vcount_in   = vcount_ff;
      count_in    = count_ff;
      drop_in     = drop_ff;
      sum_in      = sum_ff;
      clr_in      = clr_ff;
      iss_in      = iss_ff;
      chk_v_in    = 1'b0;
      chk_i_in    = chk_i_ff;
      first_in    = first_ff;
      prev_w_in   = prev_w_ff;
      prev_i_in   = prev_i_ff;
      best_v_in   = best_v_ff;
      best_in     = best_ff;
      best_i_in   = best_i_ff;
      cur_in      = cur_ff;
      x_in        = x_ff;
      side_in     = side_ff;
      ra_in       = ra_ff;
      rb_in       = rb_ff;
      rka_in      = rka_ff;
      rkb_in      = rkb_ff;
      pend_v_in   = pend_v_ff;
      pend_in     = pend_ff;
      pend_sum_in = pend_sum_ff;
      out_v_in    = out_v_ff && !rsp_if.ready;
      out_in      = out_ff;
      out_tk_in   = out_tk_ff;
      out_sum_in  = out_sum_ff;
      out_drop_in = out_drop_ff;
      out_last_in = out_last_ff;
      ew_en       = 1'b0;
      ew_addr     = count_ff[mste_pkg::EIDX_BITS-1:0];
      ew_data     = '{a: req_if.edge_from, b: req_if.edge_to, w: req_if.edge_weight};
      er_addr     = iss_ff[mste_pkg::EIDX_BITS-1:0];
      nw_en       = 1'b0;
      nw_addr     = clr_ff;
      nw_data     = '{rank: '0, parent: clr_ff};
      nr_addr     = x_ff;

      // Take a register write
      if (csr_if.valid) begin
         vcount_in = csr_if.vertex_count;
      end

      unique case (state_ff)
         mste_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (req_ok) begin
                  ew_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_if.edge_last) begin
                  clr_in   = '0;
                  first_in = 1'b1;
                  state_in = mste_pkg::ST_CLEAR;
               end
            end
         end
         mste_pkg::ST_CLEAR: begin
            // Reset each set to a single vertex
            nw_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == VB'(mste_pkg::MAX_VERTICES - 1)) begin
               iss_in    = '0;
               best_v_in = 1'b0;
               state_in  = mste_pkg::ST_SCAN;
            end
         end
         mste_pkg::ST_SCAN: begin
            if (iss_ff < count_ff) begin
               chk_v_in = 1'b1;
               chk_i_in = iss_ff[mste_pkg::EIDX_BITS-1:0];
               iss_in   = iss_ff + 1'b1;
            end
            if (chk_v_ff) begin
               if (!e_good) begin
                  drop_in = 1'b1;
               end else if (e_after && e_before) begin
                  best_v_in = 1'b1;
                  best_in   = edge_rd_ff;
                  best_i_in = chk_i_ff;
               end
            end else if (iss_ff == count_ff) begin
               if (best_v_ff) begin
                  cur_in    = best_ff;
                  prev_w_in = best_ff.w;
                  prev_i_in = best_i_ff;
                  first_in  = 1'b0;
                  x_in      = best_ff.a;
                  side_in   = 1'b0;
                  state_in  = mste_pkg::ST_FIND_RD;
               end else begin
                  state_in = mste_pkg::ST_FINISH;
               end
            end
         end
         mste_pkg::ST_FIND_RD: begin
            state_in = mste_pkg::ST_FIND_CHK;
         end
         mste_pkg::ST_FIND_CHK: begin
            // Follow the parent chain up to a root
            state_in = mste_pkg::ST_FIND_RD;
            if (node_rd_ff.parent != x_ff) begin
               x_in = node_rd_ff.parent;
            end else if (!side_ff) begin
               ra_in   = x_ff;
               rka_in  = node_rd_ff.rank;
               x_in    = cur_ff.b;
               side_in = 1'b1;
            end else begin
               rb_in  = x_ff;
               rkb_in = node_rd_ff.rank;
               if (ra_ff == x_ff) begin
                  iss_in    = '0;
                  best_v_in = 1'b0;
                  state_in  = mste_pkg::ST_SCAN;
               end else begin
                  state_in = mste_pkg::ST_JOIN;
               end
            end
         end
         mste_pkg::ST_JOIN: begin
            // Union by rank and add the weight
            nw_en = 1'b1;
            if (rka_ff < rkb_ff) begin
               nw_addr = ra_ff;
               nw_data = '{rank: rka_ff, parent: rb_ff};
            end else begin
               nw_addr = rb_ff;
               nw_data = '{rank: rkb_ff, parent: ra_ff};
            end
            if (sum_wide > mste_pkg::SUM_MAX) begin
               sum_in = SB'(mste_pkg::SUM_MAX);
            end else if (sum_wide < mste_pkg::SUM_MIN) begin
               sum_in = SB'(mste_pkg::SUM_MIN);
            end else begin
               sum_in = sum_wide[SB-1:0];
            end
            state_in = (rka_ff == rkb_ff) ? mste_pkg::ST_JOIN2 : mste_pkg::ST_EMIT;
         end
         mste_pkg::ST_JOIN2: begin
            nw_en    = 1'b1;
            nw_addr  = ra_ff;
            nw_data  = '{rank: rka_ff + 1'b1, parent: ra_ff};
            state_in = mste_pkg::ST_EMIT;
         end
         mste_pkg::ST_EMIT: begin
            // Push the held result out, hold the new one
            if (!pend_v_ff || out_free) begin
               if (pend_v_ff) begin
                  out_v_in    = 1'b1;
                  out_in      = pend_ff;
                  out_tk_in   = 1'b1;
                  out_sum_in  = pend_sum_ff;
                  out_drop_in = drop_ff;
                  out_last_in = 1'b0;
               end
               pend_v_in   = 1'b1;
               pend_in     = cur_ff;
               pend_sum_in = sum_ff;
               iss_in      = '0;
               best_v_in   = 1'b0;
               state_in    = mste_pkg::ST_SCAN;
            end
         end
         mste_pkg::ST_FINISH: begin
            // Send the final result and clear for the next graph
            if (out_free) begin
               out_v_in    = 1'b1;
               out_in      = pend_v_ff ? pend_ff : '0;
               out_tk_in   = pend_v_ff;
               out_sum_in  = pend_v_ff ? pend_sum_ff : '0;
               out_drop_in = drop_ff;
               out_last_in = 1'b1;
               pend_v_in   = 1'b0;
               count_in    = '0;
               sum_in      = '0;
               drop_in     = 1'b0;
               state_in    = mste_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mste_pkg::ST_LOAD;
         end
      endcase
   end

   // Edge store: one write, one registered read
   always_ff @(posedge clock) begin
      if (ew_en) begin
         edge_mem[ew_addr] <= ew_data;
      end
      edge_rd_ff <= edge_mem[er_addr];
   end

   // Union-find memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (nw_en) begin
         node_mem[nw_addr] <= nw_data;
      end
      node_rd_ff <= node_mem[nr_addr];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mste_pkg::ST_LOAD;
         vcount_ff <= mste_pkg::VCNT_BITS'(mste_pkg::MAX_VERTICES);
         count_ff  <= '0;
         drop_ff   <= 1'b0;
         sum_ff    <= '0;
         chk_v_ff  <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         vcount_ff <= vcount_in;
         count_ff  <= count_in;
         drop_ff   <= drop_in;
         sum_ff    <= sum_in;
         chk_v_ff  <= chk_v_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      clr_ff      <= clr_in;
      iss_ff      <= iss_in;
      chk_i_ff    <= chk_i_in;
      first_ff    <= first_in;
      prev_w_ff   <= prev_w_in;
      prev_i_ff   <= prev_i_in;
      best_v_ff   <= best_v_in;
      best_ff     <= best_in;
      best_i_ff   <= best_i_in;
      cur_ff      <= cur_in;
      x_ff        <= x_in;
      side_ff     <= side_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rka_ff      <= rka_in;
      rkb_ff      <= rkb_in;
      pend_ff     <= pend_in;
      pend_sum_ff <= pend_sum_in;
      out_ff      <= out_in;
      out_tk_ff   <= out_tk_in;
      out_sum_ff  <= out_sum_in;
      out_drop_ff <= out_drop_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_if.valid         = out_v_ff;
   assign rsp_if.tree_from     = out_ff.a;
   assign rsp_if.tree_to       = out_ff.b;
   assign rsp_if.tree_weight   = out_ff.w;
   assign rsp_if.edge_taken    = out_tk_ff;
   assign rsp_if.total_weight  = out_sum_ff;
   assign rsp_if.dropped_edges = out_drop_ff;
   assign rsp_if.result_last   = out_last_ff;

endmodule

// ===== hw/rtl/mste_checker.sv =====
// Port-level checker for the minimum spanning tree engine, bound to the top.
// Depends on mste_pkg and the assertion macros header.
`include "minimum_spanning_tree_engine_assert.svh"

module mste_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    req_last,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic [mste_pkg::VTX_BITS-1:0]           tree_from,
   input logic [mste_pkg::VTX_BITS-1:0]           tree_to,
   input logic signed [mste_pkg::WEIGHT_BITS-1:0] tree_weight,
   input logic                                    edge_taken,
   input logic signed [mste_pkg::SUM_BITS-1:0]    total_weight,
   input logic                                    result_last
);

   // A stalled result holds
   `MSTE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(total_weight) && $stable(result_last),
                     "stalled result changed")

   // The empty result is always the final one
   `MSTE_ASSERT_NOW(a_empty_last, clock, reset, rsp_valid && !edge_taken, result_last,
                    "empty result without last mark")

   // The empty result carries all-zero fields
   `MSTE_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && !edge_taken,
                    total_weight == 0 && tree_from == 0 && tree_to == 0 && tree_weight == 0,
                    "empty result not zero")

   // Stop taking requests once the last edge of a graph is in
   `MSTE_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_last,
                     !req_ready, "request taken during a run")

endmodule

bind minimum_spanning_tree_engine mste_checker u_mste_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_last     (req_if.edge_last),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .tree_from    (rsp_if.tree_from),
   .tree_to      (rsp_if.tree_to),
   .tree_weight  (rsp_if.tree_weight),
   .edge_taken   (rsp_if.edge_taken),
   .total_weight (rsp_if.total_weight),
   .result_last  (rsp_if.result_last)
);
